/* sv/itoa_pkg.sv */
// itoa_pkg: types and constants shared by the integer-to-ascii converter
// no dependencies; imported by ia_dabble and integer_to_ascii_converter
`default_nettype none

package itoa_pkg;

  localparam int VALUE_W    = 64;
  localparam int NUM_DIGITS = 20;
  localparam int DIGIT_W    = 4;
  localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
  localparam int HEX_DIGITS = VALUE_W / DIGIT_W;
  localparam int CNT_W      = $clog2(VALUE_W + 1);
  localparam int REM_W      = $clog2(NUM_DIGITS + 1);

  localparam logic       REQ_DEC = 1'b0;
  localparam logic       REQ_HEX = 1'b1;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_A     = 8'h61;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [DIGIT_W-1:0] DEC_RADIX = 4'd10;

  typedef struct packed {
    logic               req_type;
    logic [VALUE_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_last;
  } out_t;

  typedef struct packed {
    logic load;
    logic hex;
    logic shift;
  } dbl_ctl_t;

  typedef struct packed {
    logic               busy;
    logic [DIGIT_W-1:0] top_digit;
  } dbl_stat_t;

endpackage

`default_nettype wire

/* sv/ia_dabble.sv */
// ia_dabble: bit-serial binary to bcd conversion and digit shift register
// depends on itoa_pkg
`default_nettype none

module ia_dabble import itoa_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire dbl_ctl_t           ctl,
  input  wire logic [VALUE_W-1:0] mag,
  output      dbl_stat_t          stat
);

  logic [BCD_W-1:0]   digits;
  logic [BCD_W-1:0]   digits_adj;
  logic [VALUE_W-1:0] bin;
  logic [CNT_W-1:0]   cnt;
  logic               busy;

  // add-3 correction on every digit lane before the shift
  always_comb begin
    digits_adj = digits;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (digits[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
        digits_adj[i*DIGIT_W +: DIGIT_W] = digits[i*DIGIT_W +: DIGIT_W] + 4'd3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (ctl.load) begin
      if (ctl.hex) begin
        // hex digits are the nibbles themselves, top nibble in the top lane
        digits <= {mag, {(BCD_W - VALUE_W){1'b0}}};
        busy   <= 1'b0;
        cnt    <= '0;
      end else begin
        digits <= '0;
        bin    <= mag;
        busy   <= 1'b1;
        cnt    <= CNT_W'(VALUE_W);
      end
    end else if (busy) begin
      digits <= {digits_adj[BCD_W-2:0], bin[VALUE_W-1]};
      bin    <= {bin[VALUE_W-2:0], 1'b0};
      cnt    <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end else if (ctl.shift) begin
      digits <= {digits[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
    end
  end

  assign stat.busy      = busy;
  assign stat.top_digit = digits[BCD_W-1 -: DIGIT_W];

  a_cnt_live: assert property (@(posedge clk) disable iff (rst)
    busy |-> cnt != '0)
    else $error("dabble busy with zero bit count");

  a_busy_ends: assert property (@(posedge clk) disable iff (rst)
    busy && cnt == CNT_W'(1) && !ctl.load |=> !busy)
    else $error("dabble did not finish after last bit");

  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !ctl.load && !ctl.shift)
    else $error("command issued while conversion runs");

endmodule

`default_nettype wire

/* sv/integer_to_ascii_converter.sv */
// integer_to_ascii_converter: 64-bit value to decimal or hex ascii text
// depends on itoa_pkg and ia_dabble
//
// channel | signals                          | payload
// in      | in_valid, in_stall, in_data      | req_type, value
// out     | out_valid, out_stall, out_data   | char_code, is_last
//
// one value at a time; in_stall stays high from acceptance until the last
// character has been loaded into the output register
// decimal: double dabble conversion, then leading zeros dropped one per cycle,
// then one character per cycle unless out_stall holds; any minus sign first
// hex: no conversion pass, zero nibbles dropped one per cycle, then characters
// rst is synchronous; out_stall only holds the output register and the emitter
`default_nettype none

module integer_to_ascii_converter import itoa_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output      logic in_stall,
  input  wire in_t  in_data,
  output      logic out_valid,
  input  wire logic out_stall,
  output      out_t out_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_STRIP,
    ST_EMIT
  } state_t;

  state_t             state;
  logic               neg;
  logic [REM_W-1:0]   rem;
  dbl_ctl_t           ctl;
  dbl_stat_t          stat;
  logic [VALUE_W-1:0] mag;
  logic               in_take;
  logic               out_load;
  logic               strip_one;
  out_t               out_next;

  function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [7:0] c;
    if (d < DEC_RADIX) begin
      c = CHAR_ZERO + {4'd0, d};
    end else begin
      c = CHAR_A + {4'd0, d - DEC_RADIX};
    end
    return c;
  endfunction

  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;

  // magnitude taken modulo 2^64 so the most negative value needs no care
  assign mag = (in_data.req_type == REQ_DEC && in_data.value[VALUE_W-1])
             ? (~in_data.value + 1'b1) : in_data.value;

  assign out_load  = (state == ST_EMIT) && (!out_valid || !out_stall);
  assign strip_one = (state == ST_STRIP) && (stat.top_digit == '0) && (rem > REM_W'(1));

  always_comb begin
    if (neg) begin
      out_next.char_code = CHAR_MINUS;
      out_next.is_last   = 1'b0;
    end else begin
      out_next.char_code = digit_char(stat.top_digit);
      out_next.is_last   = (rem == REM_W'(1));
    end
  end

  assign ctl.load  = in_take;
  assign ctl.hex   = (in_data.req_type == REQ_HEX);
  assign ctl.shift = strip_one || (out_load && !neg);

  ia_dabble u_dabble (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .mag  (mag),
    .stat (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      neg       <= 1'b0;
      rem       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
        out_data  <= out_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_take) begin
            neg   <= (in_data.req_type == REQ_DEC) && in_data.value[VALUE_W-1];
            rem   <= (in_data.req_type == REQ_HEX) ? REM_W'(HEX_DIGITS)
                                                   : REM_W'(NUM_DIGITS);
            state <= ST_CONV;
          end
        end
        ST_CONV: begin
          if (!stat.busy) begin
            state <= ST_STRIP;
          end
        end
        ST_STRIP: begin
          if (strip_one) begin
            rem <= rem - 1'b1;
          end else begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_load) begin
            if (neg) begin
              neg <= 1'b0;
            end else begin
              rem <= rem - 1'b1;
              if (rem == REM_W'(1)) begin
                state <= ST_IDLE;
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_rem_live: assert property (@(posedge clk) disable iff (rst)
    (state == ST_STRIP || state == ST_EMIT) |-> rem != '0)
    else $error("digit count ran out before the last character");

  a_busy_in_conv: assert property (@(posedge clk) disable iff (rst)
    stat.busy |-> state == ST_CONV)
    else $error("conversion running outside conversion state");

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    out_load && out_next.is_last |=> state == ST_IDLE)
    else $error("emitter kept going after the last character");

  a_sign_first: assert property (@(posedge clk) disable iff (rst)
    out_load && out_next.char_code == CHAR_MINUS |-> !out_next.is_last)
    else $error("minus sign marked as last character");

endmodule

`default_nettype wire
